// ===== rtl/core/tmsm_pkg.sv =====
// Shared types, widths and codes for the track marker segment mapper.
// Used by tmsm_ctrl, tmsm_dp and track_marker_segment_mapper; depends on nothing.
`default_nettype none

package tmsm_pkg;

  // Sizing
  localparam int SEGMENT_SLOTS = 64;
  localparam int TICK_BITS     = 20;
  localparam int SEG_W         = $clog2(SEGMENT_SLOTS);

  // Field widths
  localparam int LEVEL_W = 10;
  localparam int SCALE_W = 10;
  localparam int MPL_W   = 2;
  localparam int IDX_W   = 6;
  localparam int DIST_W  = 19;
  localparam int SUM_W   = DIST_W + 1;
  localparam int RAD_W   = 23;
  localparam int LAP_W   = 8;
  localparam int PROD_W  = TICK_BITS + SCALE_W;

  // Divider sizing
  localparam int DIV_STEPS = RAD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Stream packing
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 96;
  localparam int OUT_USER_W = 3;

  // Saturation limits
  localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};
  localparam logic [DIST_W-1:0]    DIST_MAX = {DIST_W{1'b1}};
  localparam logic [SEG_W-1:0]     SEG_MAX  = SEG_W'(SEGMENT_SLOTS - 1);
  localparam logic [LAP_W-1:0]     LAP_MAX  = {LAP_W{1'b1}};

  // Opcodes
  localparam logic [1:0] OP_LEFT_TICK  = 2'd0;
  localparam logic [1:0] OP_RIGHT_TICK = 2'd1;
  localparam logic [1:0] OP_SAMPLE     = 2'd2;

  // Register indexes
  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_SCALE     = 2'd1;
  localparam logic [1:0] CFG_MPL       = 2'd2;

  // Register reset values
  localparam logic [LEVEL_W-1:0] THRESHOLD_RST = LEVEL_W'(650);
  localparam logic [SCALE_W-1:0] SCALE_RST     = SCALE_W'(343);
  localparam logic [MPL_W-1:0]   MPL_RST       = MPL_W'(2);

  // Sensor codes: bit 0 left sensor dark, bit 1 right sensor dark
  localparam logic [1:0] CODE_NONE  = 2'd0;
  localparam logic [1:0] CODE_LEFT  = 2'd1;
  localparam logic [1:0] CODE_RIGHT = 2'd2;
  localparam logic [1:0] CODE_BOTH  = 2'd3;

  typedef struct packed {
    logic tick_l;
    logic tick_r;
    logic sample;
    logic scale;
    logic prep;
    logic div_step;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic result;
    logic record;
    logic den_zero;
    logic div_done;
  } status_t;

  // Scaled tick count (product >> 10), saturated to the distance width
  function automatic logic [DIST_W-1:0] sat_dist(input logic [PROD_W-1:0] prod);
    logic [63:0] wide;
    wide = 64'(prod >> SCALE_W);
    return (wide > 64'(DIST_MAX)) ? DIST_MAX : DIST_W'(wide);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tmsm_ctrl.sv =====
// Sequencer of the track marker segment mapper: a marker beat goes through
// scale, prepare, divide and output, a crossing to output. Depends on tmsm_pkg.
`default_nettype none

module tmsm_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [1:0]      opcode_i,
  input  wire logic            out_ready_i,
  output logic                 out_valid_o,
  input  wire tmsm_pkg::status_t st_i,
  output tmsm_pkg::cmd_t       cmd_o
);
  import tmsm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_PREP,
    S_DIVIDE,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.tick_l = (opcode_i == OP_LEFT_TICK);
          cmd_o.tick_r = (opcode_i == OP_RIGHT_TICK);
          cmd_o.sample = (opcode_i == OP_SAMPLE);
          if (opcode_i == OP_SAMPLE && st_i.record) begin
            state_d = S_SCALE;
          end else if (opcode_i == OP_SAMPLE && st_i.result) begin
            state_d = S_FINISH;
          end
        end
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_PREP;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_DIVIDE;
      end
      S_DIVIDE: begin
        if (st_i.den_zero) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.div_step = 1'b1;
          if (st_i.div_done) begin
            state_d = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A tick or an ignored opcode completes in the accepting cycle
  a_tick_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && opcode_i != OP_SAMPLE) |=> (state_q == S_IDLE))
    else $error("non-sample beat left the idle state");

  // A finished record with a free slot is shown on the next cycle
  a_finish_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && slot_free) |=> (state_q == S_IDLE && out_valid_q))
    else $error("finished record not presented");

  // The last divider step hands over to the output stage
  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVIDE && !st_i.den_zero && st_i.div_done) |=> (state_q == S_FINISH))
    else $error("divider did not hand over after its last step");

endmodule

`default_nettype wire

// ===== rtl/core/tmsm_dp.sv =====
// Datapath of the track marker segment mapper: registers, code history,
// tick counters, scaling, radix-2 divider and output holding. Depends on tmsm_pkg.
`default_nettype none

module tmsm_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_index_i,
  input  wire logic [tmsm_pkg::LEVEL_W-1:0]  cfg_data_i,
  input  wire logic [tmsm_pkg::LEVEL_W-1:0]  left_level_i,
  input  wire logic [tmsm_pkg::LEVEL_W-1:0]  right_level_i,
  input  wire tmsm_pkg::cmd_t                cmd_i,
  output tmsm_pkg::status_t                  st_o,
  output logic                               left_marker_o,
  output logic                               right_marker_o,
  output logic                               crossing_o,
  output logic                               lap_end_o,
  output logic [tmsm_pkg::IDX_W-1:0]         record_index_o,
  output logic [tmsm_pkg::DIST_W-1:0]        left_distance_o,
  output logic [tmsm_pkg::DIST_W-1:0]        right_distance_o,
  output logic [tmsm_pkg::DIST_W-1:0]        mean_distance_o,
  output logic [tmsm_pkg::RAD_W-1:0]         curve_radius_o,
  output logic                               radius_valid_o,
  output logic [tmsm_pkg::LAP_W-1:0]         lap_number_o
);
  import tmsm_pkg::*;

  // Configuration
  logic [LEVEL_W-1:0] thr_q;
  logic [SCALE_W-1:0] scl_q;
  logic [MPL_W-1:0]   mpl_q;

  // Track state
  logic [1:0]           c1_q, c2_q, c3_q;
  logic [TICK_BITS-1:0] lt_q, lt_d, rt_q, rt_d;
  logic [1:0]           mc_q, mc_d;
  logic [SEG_W-1:0]     seg_q, seg_d;
  logic [LAP_W-1:0]     laps_q, laps_d;
  logic                 lap_end_d;

  // Latched event of the beat in flight
  logic             lm_q, rm_q, cr_q, le_q, rec_q;
  logic [IDX_W-1:0] idx_q;

  // Scale, prepare and divide
  logic [DIST_W-1:0] a_q, b_q;
  logic [SUM_W-1:0]  sum;
  logic [DIST_W-1:0] diff;
  logic [DIST_W-1:0] mean_q, den_q;
  logic [RAD_W-1:0]  quo_q;
  logic [DIST_W-1:0] rem_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DIST_W:0]   rem_sh;
  logic              ge;

  // Sample decode
  logic [1:0] code;
  logic       changed, right_w, left_w, cross_w;

  // Output holding
  logic              o_lm_q, o_rm_q, o_cr_q, o_le_q, o_rv_q;
  logic [IDX_W-1:0]  o_idx_q;
  logic [DIST_W-1:0] o_ld_q, o_rd_q, o_mean_q;
  logic [RAD_W-1:0]  o_rad_q;
  logic [LAP_W-1:0]  o_lap_q;

  assign code    = {right_level_i < thr_q, left_level_i < thr_q};
  assign changed = (code != c1_q);
  assign right_w = changed && code == CODE_NONE && c1_q == CODE_LEFT && c2_q == CODE_NONE;
  assign left_w  = changed && code == CODE_NONE && c1_q == CODE_RIGHT && c2_q == CODE_NONE;
  assign cross_w = changed && code == CODE_NONE &&
                   (c1_q == CODE_BOTH || c2_q == CODE_BOTH || c3_q == CODE_BOTH);

  assign sum    = SUM_W'(a_q) + SUM_W'(b_q);
  assign diff   = (a_q > b_q) ? (a_q - b_q) : (b_q - a_q);
  assign rem_sh = {rem_q, quo_q[RAD_W-1]};
  assign ge     = (rem_sh >= {1'b0, den_q});

  assign st_o.result   = right_w || left_w || cross_w;
  assign st_o.record   = right_w || left_w;
  assign st_o.den_zero = (den_q == '0);
  assign st_o.div_done = (cnt_q == CNT_W'(DIV_STEPS - 1));

  // Tick counters: saturate, clear when a segment closes
  always_comb begin
    lt_d = lt_q;
    rt_d = rt_q;
    if (cmd_i.scale) begin
      lt_d = '0;
      rt_d = '0;
    end else begin
      if (cmd_i.tick_l && lt_q != TICK_MAX) lt_d = lt_q + 1'b1;
      if (cmd_i.tick_r && rt_q != TICK_MAX) rt_d = rt_q + 1'b1;
    end
  end

  // Segment, marker and lap bookkeeping
  always_comb begin
    mc_d      = mc_q;
    seg_d     = seg_q;
    laps_d    = laps_q;
    lap_end_d = 1'b0;
    if (cmd_i.sample && right_w) begin
      mc_d  = (mc_q == 2'd3) ? mc_q : mc_q + 2'd1;
      seg_d = (seg_q < SEG_MAX) ? seg_q + 1'b1 : seg_q;
      if (mc_d >= mpl_q) begin
        laps_d    = (laps_q == LAP_MAX) ? laps_q : laps_q + 1'b1;
        seg_d     = '0;
        mc_d      = '0;
        lap_end_d = 1'b1;
      end
    end else if (cmd_i.sample && left_w) begin
      seg_d = (seg_q < SEG_MAX) ? seg_q + 1'b1 : seg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THRESHOLD_RST;
      scl_q  <= SCALE_RST;
      mpl_q  <= MPL_RST;
      c1_q   <= CODE_NONE;
      c2_q   <= CODE_NONE;
      c3_q   <= CODE_NONE;
      lt_q   <= '0;
      rt_q   <= '0;
      mc_q   <= '0;
      seg_q  <= '0;
      laps_q <= LAP_W'(1);
      cnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_THRESHOLD: thr_q <= cfg_data_i;
          CFG_SCALE:     scl_q <= SCALE_W'(cfg_data_i);
          CFG_MPL:       mpl_q <= cfg_data_i[MPL_W-1:0];
          default:       ;
        endcase
      end
      if (cmd_i.sample && changed) begin
        c3_q <= c2_q;
        c2_q <= c1_q;
        c1_q <= code;
      end
      lt_q   <= lt_d;
      rt_q   <= rt_d;
      mc_q   <= mc_d;
      seg_q  <= seg_d;
      laps_q <= laps_d;
      if (cmd_i.prep) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Event latch, scaling, divider operands and quotient
  always_ff @(posedge clk_i) begin
    if (cmd_i.sample) begin
      lm_q  <= left_w;
      rm_q  <= right_w;
      cr_q  <= cross_w;
      le_q  <= lap_end_d;
      rec_q <= right_w || left_w;
      idx_q <= IDX_W'(seg_q);
    end
    if (cmd_i.scale) begin
      a_q <= sat_dist(PROD_W'(lt_q) * PROD_W'(scl_q));
      b_q <= sat_dist(PROD_W'(rt_q) * PROD_W'(scl_q));
    end
    if (cmd_i.prep) begin
      mean_q <= sum[SUM_W-1:1];
      den_q  <= diff;
      quo_q  <= RAD_W'({sum, 2'b00}) + RAD_W'({sum, 1'b0});
      rem_q  <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? DIST_W'(rem_sh - {1'b0, den_q}) : DIST_W'(rem_sh);
      quo_q <= {quo_q[RAD_W-2:0], ge};
    end
  end

  // Output holding register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_lm_q   <= 1'b0;
      o_rm_q   <= 1'b0;
      o_cr_q   <= 1'b0;
      o_le_q   <= 1'b0;
      o_rv_q   <= 1'b0;
      o_idx_q  <= '0;
      o_ld_q   <= '0;
      o_rd_q   <= '0;
      o_mean_q <= '0;
      o_rad_q  <= '0;
      o_lap_q  <= LAP_W'(1);
    end else if (cmd_i.load) begin
      o_lm_q   <= lm_q;
      o_rm_q   <= rm_q;
      o_cr_q   <= cr_q;
      o_le_q   <= le_q;
      o_rv_q   <= rec_q && den_q != '0;
      o_idx_q  <= rec_q ? idx_q : '0;
      o_ld_q   <= rec_q ? a_q : '0;
      o_rd_q   <= rec_q ? b_q : '0;
      o_mean_q <= rec_q ? mean_q : '0;
      o_rad_q  <= (rec_q && den_q != '0) ? quo_q : '0;
      o_lap_q  <= laps_q;
    end
  end

  assign left_marker_o    = o_lm_q;
  assign right_marker_o   = o_rm_q;
  assign crossing_o       = o_cr_q;
  assign lap_end_o        = o_le_q;
  assign record_index_o   = o_idx_q;
  assign left_distance_o  = o_ld_q;
  assign right_distance_o = o_rd_q;
  assign mean_distance_o  = o_mean_q;
  assign curve_radius_o   = o_rad_q;
  assign radius_valid_o   = o_rv_q;
  assign lap_number_o     = o_lap_q;

  // A valid radius comes only from unequal distances
  a_rv_diff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_rv_q |-> (o_ld_q != o_rd_q))
    else $error("radius flagged valid with equal distances");

  // The mean lies between the two distances
  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_mean_q <= ((o_ld_q > o_rd_q) ? o_ld_q : o_rd_q)) &&
    (o_mean_q >= ((o_ld_q > o_rd_q) ? o_rd_q : o_ld_q)))
    else $error("mean distance outside the two distances");

  // Lap count never wraps to zero
  a_laps_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    laps_q != '0)
    else $error("lap counter reached zero");

endmodule

`default_nettype wire

// ===== rtl/core/track_marker_segment_mapper.sv =====
// Top level of the track marker segment mapper: stream and register ports,
// joins tmsm_ctrl and tmsm_dp. Depends on tmsm_pkg, tmsm_ctrl, tmsm_dp.
//
//   Channel   Dir  Handshake                    Payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  tuser opcode, tdata sensor levels
//   m_axis    out  m_axis_tvalid/m_axis_tready  tuser event flags, tlast lap end,
//                                               tdata segment record
//   cfg       in   cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// Sequence: a tick beat, an ignored opcode or a sample without an event ends in
// idle; a crossing alone goes straight to the output load; a marker passes scale,
// prepare, 23 steps of the shared radix-2 divider and output load, skipping the
// divider when both distances are equal. No new beat is taken until the load.
// Reset: rst_ni clears control, registers go to defaults, lap count to one.
// Stalls: a finished record sits in the output register while the next beats
// flow; a new record waits in the output stage only while that register is full.
`default_nettype none

module track_marker_segment_mapper (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Input stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [9:0] left_level, [19:10] right_level, [23:20] zero
  input  wire logic [tmsm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] opcode
  input  wire logic [tmsm_pkg::IN_USER_W-1:0]  s_axis_tuser,
  // Output stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [5:0] record_index, [24:6] left_distance, [43:25] right_distance,
  // [62:44] mean_distance, [85:63] curve_radius, [86] radius_valid,
  // [94:87] lap_number, [95] zero
  output logic [tmsm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // [0] left_marker, [1] right_marker, [2] crossing
  output logic [tmsm_pkg::OUT_USER_W-1:0]      m_axis_tuser,
  // lap_end: last record of a lap
  output logic                                 m_axis_tlast,
  // Register writes
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [1:0]                      cfg_index_i,
  input  wire logic [tmsm_pkg::LEVEL_W-1:0]    cfg_data_i
);
  import tmsm_pkg::*;

  cmd_t    cmd;
  status_t st;

  logic              left_marker, right_marker, crossing, lap_end, radius_valid;
  logic [IDX_W-1:0]  record_index;
  logic [DIST_W-1:0] left_distance, right_distance, mean_distance;
  logic [RAD_W-1:0]  curve_radius;
  logic [LAP_W-1:0]  lap_number;

  // Registers take a beat at any time; writes land only while idle by contract
  assign cfg_ready_o = 1'b1;

  tmsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .opcode_i    (s_axis_tuser[1:0]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  tmsm_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .left_level_i     (s_axis_tdata[LEVEL_W-1:0]),
    .right_level_i    (s_axis_tdata[2*LEVEL_W-1:LEVEL_W]),
    .cmd_i            (cmd),
    .st_o             (st),
    .left_marker_o    (left_marker),
    .right_marker_o   (right_marker),
    .crossing_o       (crossing),
    .lap_end_o        (lap_end),
    .record_index_o   (record_index),
    .left_distance_o  (left_distance),
    .right_distance_o (right_distance),
    .mean_distance_o  (mean_distance),
    .curve_radius_o   (curve_radius),
    .radius_valid_o   (radius_valid),
    .lap_number_o     (lap_number)
  );

  // Pack the record, first field in the low bits
  assign m_axis_tdata = {1'b0, lap_number, radius_valid, curve_radius, mean_distance,
                         right_distance, left_distance, record_index};
  assign m_axis_tuser = {crossing, right_marker, left_marker};
  assign m_axis_tlast = lap_end;

endmodule

`default_nettype wire

// ===== test/tb_track_marker_segment_mapper.sv =====
// Testbench for track_marker_segment_mapper: drives tick and sensor beats, writes the
// registers between phases and checks every segment record against an in-bench tracker or a typed row.
// Depends on tmsm_pkg and the RTL of the block; nothing else.

module tb_track_marker_segment_mapper;
  timeunit 1ns;
  timeprecision 1ps;

  import tmsm_pkg::*;

  localparam logic [1:0] OP_IGNORED     = 2'd3;   // opcode the block drops
  localparam int         HOLD_CYCLES    = 400;    // long receiver hold-off
  localparam int         SETTLE_CYCLES  = 40;     // above the marker latency
  localparam int         WATCHDOG_LIMIT = 5000;   // cycles without any beat
  localparam int         REPORT_MAX     = 40;     // printed mismatch lines

  typedef struct packed {
    logic              left_mark;
    logic              right_mark;
    logic              crossing;
    logic              lap_end;
    logic [IDX_W-1:0]  index;
    logic [DIST_W-1:0] left_dist;
    logic [DIST_W-1:0] right_dist;
    logic [DIST_W-1:0] mean_dist;
    logic [RAD_W-1:0]  radius;
    logic              radius_ok;
    logic [LAP_W-1:0]  lap;
  } seg_record_t;

  typedef struct {
    logic [1:0]         op;
    logic [LEVEL_W-1:0] lvl_l;
    logic [LEVEL_W-1:0] lvl_r;
    bit                 typed;
    seg_record_t        rec;
  } stim_row_t;

  typedef enum {SEG_RIGHT, SEG_LEFT, SEG_CROSS, SEG_NOISE} seg_kind_e;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // DUT ports, every input known from time zero
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [1:0]            cfg_index_i   = '0;
  logic [LEVEL_W-1:0]    cfg_data_i    = '0;

  track_marker_segment_mapper u_top (.*);

  // Tracker state, mirrors the block from reset on
  logic [1:0]           hist1     = CODE_NONE;
  logic [1:0]           hist2     = CODE_NONE;
  logic [1:0]           hist3     = CODE_NONE;
  logic [TICK_BITS-1:0] lticks    = '0;
  logic [TICK_BITS-1:0] rticks    = '0;
  logic [1:0]           mark_cnt  = '0;
  logic [SEG_W-1:0]     seg_cnt   = '0;
  logic [LAP_W-1:0]     lap_cnt   = LAP_W'(1);
  logic [LEVEL_W-1:0]   cfg_thr   = THRESHOLD_RST;
  logic [SCALE_W-1:0]   cfg_scale = SCALE_RST;
  logic [MPL_W-1:0]     cfg_mpl   = MPL_RST;

  // Records still owed by the block, oldest first
  seg_record_t due_records[$];

  // Typed expectation that travels with the current beat (directed rows only)
  bit          beat_typed = 1'b0;
  seg_record_t beat_rec   = '0;

  int err_cnt     = 0;
  int idle_cycles = 0;
  int beats_sent  = 0;
  int burst_left  = 0;
  bit gaps_on     = 1'b1;
  int hold_asks   = 0;

  stim_row_t dir_rows[$];

  // ---------------------------------------------------------------------------
  // Tracker: scaled distances, radius and lap bookkeeping
  // ---------------------------------------------------------------------------
  function automatic logic [DIST_W-1:0] to_distance(input logic [TICK_BITS-1:0] ticks);
    longint unsigned prod;
    prod = ticks;
    prod = (prod * cfg_scale) >> SCALE_W;
    return (prod > DIST_MAX) ? DIST_MAX : DIST_W'(prod);
  endfunction

  // Close the running segment: fill the record, clear the wheel counts and advance the index.
  function automatic void close_segment(inout seg_record_t rec);
    logic [DIST_W-1:0] a;
    logic [DIST_W-1:0] b;
    longint unsigned   sum;
    longint unsigned   diff;
    a    = to_distance(lticks);
    b    = to_distance(rticks);
    sum  = a;
    sum  = sum + b;
    diff = (a > b) ? a - b : b - a;
    rec.index      = IDX_W'(seg_cnt);
    rec.left_dist  = a;
    rec.right_dist = b;
    rec.mean_dist  = DIST_W'(sum >> 1);
    if (diff != 0) begin
      rec.radius    = RAD_W'((6 * sum) / diff);
      rec.radius_ok = 1'b1;
    end
    lticks = '0;
    rticks = '0;
    if (seg_cnt < SEG_MAX) seg_cnt = seg_cnt + 1'b1;
  endfunction

  // Advance the tracker by one beat; returns 1 when the beat yields a record.
  function automatic bit update_track(input logic [1:0] op, input logic [LEVEL_W-1:0] lvl_l,
                                      input logic [LEVEL_W-1:0] lvl_r,
                                      output seg_record_t rec);
    logic [1:0] code;
    bit         rgt;
    bit         lft;
    bit         crs;
    rec = '0;
    if (op == OP_LEFT_TICK) begin
      if (lticks < TICK_MAX) lticks = lticks + 1'b1;
      return 1'b0;
    end
    if (op == OP_RIGHT_TICK) begin
      if (rticks < TICK_MAX) rticks = rticks + 1'b1;
      return 1'b0;
    end
    if (op != OP_SAMPLE) return 1'b0;

    code = {lvl_r < cfg_thr, lvl_l < cfg_thr};
    if (code == hist1) return 1'b0;

    rgt = code == CODE_NONE && hist1 == CODE_LEFT && hist2 == CODE_NONE;
    lft = code == CODE_NONE && hist1 == CODE_RIGHT && hist2 == CODE_NONE;
    crs = code == CODE_NONE &&
          (hist1 == CODE_BOTH || hist2 == CODE_BOTH || hist3 == CODE_BOTH);
    hist3 = hist2;
    hist2 = hist1;
    hist1 = code;
    if (!(rgt || lft || crs)) return 1'b0;

    rec.left_mark  = lft;
    rec.right_mark = rgt;
    rec.crossing   = crs;
    if (rgt) begin
      if (mark_cnt < 2'd3) mark_cnt = mark_cnt + 1'b1;
      close_segment(rec);
      if (mark_cnt >= cfg_mpl) begin
        if (lap_cnt < LAP_MAX) lap_cnt = lap_cnt + 1'b1;
        seg_cnt     = '0;
        mark_cnt    = '0;
        rec.lap_end = 1'b1;
      end
    end else if (lft) begin
      close_segment(rec);
    end
    rec.lap = lap_cnt;
    return 1'b1;
  endfunction

  // Event-only record with zero distances, for hand-written expectations.
  function automatic seg_record_t event_record(input bit lft, input bit rgt, input bit crs,
                                               input bit lend, input int idx, input int lap);
    seg_record_t rec;
    rec            = '0;
    rec.left_mark  = lft;
    rec.right_mark = rgt;
    rec.crossing   = crs;
    rec.lap_end    = lend;
    rec.index      = IDX_W'(idx);
    rec.lap        = LAP_W'(lap);
    return rec;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (err_cnt < REPORT_MAX)
      $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
    err_cnt++;
  endtask

  task automatic check_record(input seg_record_t got, input seg_record_t want);
    if (got.left_mark != want.left_mark)
      report_mismatch("left_marker", got.left_mark, want.left_mark);
    if (got.right_mark != want.right_mark)
      report_mismatch("right_marker", got.right_mark, want.right_mark);
    if (got.crossing != want.crossing)
      report_mismatch("crossing", got.crossing, want.crossing);
    if (got.lap_end != want.lap_end)
      report_mismatch("lap_end", got.lap_end, want.lap_end);
    if (got.index != want.index)
      report_mismatch("record_index", got.index, want.index);
    if (got.left_dist != want.left_dist)
      report_mismatch("left_distance", got.left_dist, want.left_dist);
    if (got.right_dist != want.right_dist)
      report_mismatch("right_distance", got.right_dist, want.right_dist);
    if (got.mean_dist != want.mean_dist)
      report_mismatch("mean_distance", got.mean_dist, want.mean_dist);
    if (got.radius != want.radius)
      report_mismatch("curve_radius", got.radius, want.radius);
    if (got.radius_ok != want.radius_ok)
      report_mismatch("radius_valid", got.radius_ok, want.radius_ok);
    if (got.lap != want.lap)
      report_mismatch("lap_number", got.lap, want.lap);
  endtask

  // Sample every channel at the rising edge; DUT outputs still hold pre-edge values here.
  always @(posedge clk_i) begin
    seg_record_t got;
    seg_record_t fresh;
    bit          has_rec;
    bit          busy;
    if (rst_ni) begin
      busy = 1'b0;
      if (m_axis_tvalid && m_axis_tready) begin
        busy           = 1'b1;
        got.left_mark  = m_axis_tuser[0];
        got.right_mark = m_axis_tuser[1];
        got.crossing   = m_axis_tuser[2];
        got.lap_end    = m_axis_tlast;
        got.index      = m_axis_tdata[5:0];
        got.left_dist  = m_axis_tdata[24:6];
        got.right_dist = m_axis_tdata[43:25];
        got.mean_dist  = m_axis_tdata[62:44];
        got.radius     = m_axis_tdata[85:63];
        got.radius_ok  = m_axis_tdata[86];
        got.lap        = m_axis_tdata[94:87];
        if (due_records.size() == 0)
          report_mismatch("record with none due, lap_number", got.lap, 0);
        else
          check_record(got, due_records.pop_front());
      end
      // Predict on input acceptance; a typed row overrides the tracker's record.
      if (s_axis_tvalid && s_axis_tready) begin
        busy    = 1'b1;
        has_rec = update_track(s_axis_tuser, s_axis_tdata[9:0], s_axis_tdata[19:10], fresh);
        if (beat_typed) due_records.push_back(beat_rec);
        else if (has_rec) due_records.push_back(fresh);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        busy = 1'b1;
        case (cfg_index_i)
          CFG_THRESHOLD: cfg_thr   = cfg_data_i;
          CFG_SCALE:     cfg_scale = SCALE_W'(cfg_data_i);
          CFG_MPL:       cfg_mpl   = cfg_data_i[MPL_W-1:0];
          default: ;
        endcase
      end
      idle_cycles <= busy ? 0 : idle_cycles + 1;
    end
  end

  // Watchdog: end the run when no beat moves for too long.
  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: rotating stall modes, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : receiver
    static int       hold_left  = 0;
    static int       hold_done  = 0;
    static int       mode_left  = 0;
    static int       stall_mode = 0;
    static int       mask_pos   = 0;
    static bit [7:0] stall_mask = 8'hFF;
    if (hold_asks != hold_done) begin
      hold_done = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_mask = 8'($urandom);
      mode_left  = $urandom_range(64, 256);
    end
    mode_left--;
    mask_pos = (mask_pos + 1) % 8;
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (stall_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= $urandom_range(0, 3) != 0;
        2:       m_axis_tready <= stall_mask[mask_pos];
        default: m_axis_tready <= $urandom_range(0, 3) == 0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // Offer one beat at the falling edge and hold it until accepted; bursts of
  // random length are separated by random gaps unless gaps are switched off.
  task automatic send_beat(input logic [1:0] op, input logic [LEVEL_W-1:0] lvl_l,
                           input logic [LEVEL_W-1:0] lvl_r, input bit typed,
                           input seg_record_t rec);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 12) : 0;
      if (gap != 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0, lvl_r, lvl_l};
    beat_typed    <= typed;
    beat_rec      <= rec;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    beats_sent++;
  endtask

  // Level on the chosen side of the threshold, often right at the boundary; any level for dark at zero threshold.
  function automatic logic [LEVEL_W-1:0] pick_level(input bit dark);
    if (dark && cfg_thr == 0) return LEVEL_W'($urandom_range(0, 1023));
    if (dark)
      return ($urandom_range(0, 3) == 0) ? cfg_thr - 1'b1
                                         : LEVEL_W'($urandom_range(0, cfg_thr - 1));
    return ($urandom_range(0, 3) == 0) ? cfg_thr : LEVEL_W'($urandom_range(cfg_thr, 1023));
  endfunction

  task automatic drive_code(input logic [1:0] code);
    send_beat(OP_SAMPLE, pick_level(code[0]), pick_level(code[1]), 1'b0, '0);
  endtask

  task automatic drive_ticks(input int nl, input int nr);
    while (nl + nr != 0) begin
      if (nl != 0 && (nr == 0 || $urandom_range(0, 1) == 1)) begin
        send_beat(OP_LEFT_TICK, LEVEL_W'($urandom), LEVEL_W'($urandom), 1'b0, '0);
        nl--;
      end else begin
        send_beat(OP_RIGHT_TICK, LEVEL_W'($urandom), LEVEL_W'($urandom), 1'b0, '0);
        nr--;
      end
    end
  endtask

  // One piece of track: wheel ticks, then a sensor pattern; the noise kind sends raw beats only.
  task automatic drive_segment(input seg_kind_e kind, input int tick_max);
    int n;
    int pos_both;
    if (kind != SEG_NOISE) begin
      if ($urandom_range(0, 9) == 0)
        drive_ticks($urandom_range(0, 300), $urandom_range(0, 300));
      else
        drive_ticks($urandom_range(0, tick_max), $urandom_range(0, tick_max));
      drive_code(CODE_NONE);
    end
    case (kind)
      SEG_RIGHT: begin
        repeat ($urandom_range(1, 2)) drive_code(CODE_LEFT);
        drive_code(CODE_NONE);
      end
      SEG_LEFT: begin
        repeat ($urandom_range(1, 2)) drive_code(CODE_RIGHT);
        drive_code(CODE_NONE);
      end
      SEG_CROSS: begin
        n        = $urandom_range(1, 3);
        pos_both = $urandom_range(0, n - 1);
        for (int i = 0; i < n; i++)
          drive_code(i == pos_both ? CODE_BOTH : 2'($urandom_range(1, 3)));
        drive_code(CODE_NONE);
      end
      default: begin
        // Noise: raw samples over the full level range, and the unused opcode.
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 3) == 0)
            send_beat(OP_IGNORED, LEVEL_W'($urandom), LEVEL_W'($urandom), 1'b0, '0);
          else
            send_beat(OP_SAMPLE, LEVEL_W'($urandom), LEVEL_W'($urandom), 1'b0, '0);
        end
      end
    endcase
  endtask

  function automatic seg_kind_e pick_kind(input int w_right, input int w_left,
                                          input int w_cross);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < w_right) return SEG_RIGHT;
    if (roll < w_right + w_left) return SEG_LEFT;
    if (roll < w_right + w_left + w_cross) return SEG_CROSS;
    return SEG_NOISE;
  endfunction

  task automatic run_mix(input int beats, input int w_right, input int w_left,
                         input int w_cross, input int tick_max);
    int start;
    start = beats_sent;
    while (beats_sent - start < beats)
      drive_segment(pick_kind(w_right, w_left, w_cross), tick_max);
  endtask

  // Drop valid, wait for every owed record, then let the block fall idle.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (due_records.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [LEVEL_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Directed rows under the reset register values. Typed records are events
    // with zero distances; the rest come from the tracker.
    dir_rows.push_back('{OP_IGNORED,    10'h3FF, 10'h3FF, 1'b0, '0});
    dir_rows.push_back('{OP_SAMPLE,     10'h3FF, 10'h3FF, 1'b0, '0});  // no change
    dir_rows.push_back('{OP_SAMPLE,     10'h3FF, 10'h000, 1'b0, '0});  // right dark
    dir_rows.push_back('{OP_SAMPLE,     10'h3FF, 10'h3FF, 1'b1,
                         event_record(1'b1, 1'b0, 1'b0, 1'b0, 0, 1)}); // left marker
    dir_rows.push_back('{OP_LEFT_TICK,  10'h000, 10'h000, 1'b0, '0});
    dir_rows.push_back('{OP_SAMPLE,     10'h000, 10'h3FF, 1'b0, '0});  // left dark
    dir_rows.push_back('{OP_SAMPLE,     10'd650, 10'd650, 1'b1,
                         event_record(1'b0, 1'b1, 1'b0, 1'b0, 1, 1)}); // right marker
    dir_rows.push_back('{OP_SAMPLE,     10'd649, 10'd649, 1'b0, '0});  // both dark
    dir_rows.push_back('{OP_SAMPLE,     10'h3FF, 10'h3FF, 1'b1,
                         event_record(1'b0, 1'b0, 1'b1, 1'b0, 0, 1)}); // crossing alone
    dir_rows.push_back('{OP_LEFT_TICK,  10'h2AA, 10'h155, 1'b0, '0});
    dir_rows.push_back('{OP_LEFT_TICK,  10'h155, 10'h2AA, 1'b0, '0});
    dir_rows.push_back('{OP_LEFT_TICK,  10'h3FF, 10'h000, 1'b0, '0});
    dir_rows.push_back('{OP_RIGHT_TICK, 10'h3FF, 10'h3FF, 1'b0, '0});
    dir_rows.push_back('{OP_SAMPLE,     10'h3FF, 10'h000, 1'b0, '0});
    dir_rows.push_back('{OP_SAMPLE,     10'h3FF, 10'h3FF, 1'b0, '0});  // left + crossing
    dir_rows.push_back('{OP_SAMPLE,     10'h000, 10'h3FF, 1'b0, '0});
    dir_rows.push_back('{OP_SAMPLE,     10'h3FF, 10'h3FF, 1'b0, '0});  // right, lap end
    dir_rows.push_back('{OP_SAMPLE,     10'h000, 10'h000, 1'b0, '0});
    dir_rows.push_back('{OP_SAMPLE,     10'h000, 10'h3FF, 1'b0, '0});  // both -> left
    dir_rows.push_back('{OP_SAMPLE,     10'h001, 10'h3FE, 1'b0, '0});  // same code
    dir_rows.push_back('{OP_SAMPLE,     10'h3FF, 10'h3FF, 1'b0, '0});  // crossing via hist
    dir_rows.push_back('{OP_IGNORED,    10'h000, 10'h000, 1'b0, '0});

    // Hold reset, then release it at a falling edge.
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i])
      send_beat(dir_rows[i].op, dir_rows[i].lvl_l, dir_rows[i].lvl_r,
                dir_rows[i].typed, dir_rows[i].rec);
    settle();

    // Reset values, mixed track; the long receiver hold-off lands mid-phase.
    run_mix(80, 30, 30, 25, 40);
    hold_asks++;
    run_mix(80, 30, 30, 25, 40);
    settle();

    // Top extremes, back-to-back beats with no sender gaps.
    write_reg(CFG_THRESHOLD, 10'd1023);
    write_reg(CFG_SCALE, 10'd1023);
    write_reg(CFG_MPL, 10'd3);
    gaps_on = 1'b0;
    run_mix(120, 30, 30, 25, 60);
    gaps_on = 1'b1;
    settle();

    // Zero threshold: no sensor can ever read dark, so no record is due.
    write_reg(CFG_THRESHOLD, 10'd0);
    run_mix(30, 40, 30, 30, 3);
    settle();

    // Zero scale and mostly left markers, then a tight run of left markers
    // that drives the segment index into saturation.
    write_reg(CFG_THRESHOLD, 10'd512);
    write_reg(CFG_SCALE, 10'd0);
    run_mix(40, 3, 90, 4, 2);
    drive_code(CODE_NONE);
    repeat (70) begin
      drive_code(CODE_RIGHT);
      drive_code(CODE_NONE);
    end
    settle();

    // Upper bits of the lap register ignored, zero low bits: every right marker
    // ends a lap. Go on until the lap count saturates and a dozen markers beyond.
    write_reg(CFG_THRESHOLD, LEVEL_W'($urandom_range(100, 900)));
    write_reg(CFG_SCALE, 10'd1);
    write_reg(CFG_MPL, 10'h3FC);
    drive_code(CODE_NONE);
    while (lap_cnt != LAP_MAX) begin
      drive_code(CODE_LEFT);
      drive_code(CODE_NONE);
    end
    repeat (12) begin
      drive_ticks($urandom_range(0, 2), $urandom_range(0, 2));
      drive_code(CODE_LEFT);
      drive_code(CODE_NONE);
    end
    settle();

    // Random settings, one marker per lap.
    write_reg(CFG_THRESHOLD, LEVEL_W'($urandom_range(1, 1023)));
    write_reg(CFG_SCALE, LEVEL_W'($urandom_range(1, 1023)));
    write_reg(CFG_MPL, 10'd1);
    run_mix(120, 30, 30, 25, 40);
    settle();

    if (err_cnt == 0 && due_records.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/tmsm_pkg.sv
rtl/core/tmsm_ctrl.sv
rtl/core/tmsm_dp.sv
rtl/core/track_marker_segment_mapper.sv
test/tb_track_marker_segment_mapper.sv
